### hw/rtl/autorange_voltmeter_display_unit_macros.svh
// Assertion macros shared by the autoranging voltmeter display RTL.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef AUTORANGE_VOLTMETER_DISPLAY_UNIT_MACROS_SVH
`define AUTORANGE_VOLTMETER_DISPLAY_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define AVD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define AVD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/avd_pkg.sv
// Shared types, constants and the segment decoder for the voltmeter display.
// No dependencies; imported by every module of the block.
`default_nettype none

package avd_pkg;

  // Range decision and scaling constants
  localparam logic [9:0]  VOLT_THRESH = 10'd205;
  localparam logic [16:0] K_VOLT      = 17'd10000;
  localparam logic [16:0] K_MILLI     = 17'd100000;
  localparam logic [26:0] ROUND_ADD   = 27'd1023;
  localparam logic [13:0] LIM_VOLT    = 14'd5000;
  localparam logic [13:0] LIM_MILLI   = 14'd9999;
  localparam logic [1:0]  PT_VOLT     = 2'd0;
  localparam logic [1:0]  PT_MILLI    = 2'd2;
  localparam logic [7:0]  DP_BIT      = 8'h80;

  // Reciprocal of 2046 for a 27-bit numerator: shift 38
  localparam int unsigned           SH_2046 = 38;
  localparam longint unsigned       M_2046_L = ((64'd1 << SH_2046) + 64'd2045) / 64'd2046;
  localparam logic [27:0]           M_2046  = M_2046_L[27:0];

  // Reciprocals of 1000, 100, 10 for a 14-bit numerator
  localparam int unsigned           SH_1000 = 24;
  localparam int unsigned           SH_100  = 21;
  localparam int unsigned           SH_10   = 18;
  localparam longint unsigned       M_1000_L = ((64'd1 << SH_1000) + 64'd999) / 64'd1000;
  localparam longint unsigned       M_100_L  = ((64'd1 << SH_100) + 64'd99) / 64'd100;
  localparam longint unsigned       M_10_L   = ((64'd1 << SH_10) + 64'd9) / 64'd10;
  localparam logic [14:0]           M_1000  = M_1000_L[14:0];
  localparam logic [14:0]           M_100   = M_100_L[14:0];
  localparam logic [14:0]           M_10    = M_10_L[14:0];

  // New average headed for the display update
  typedef struct packed {
    logic       valid;
    logic [9:0] avg;
  } avd_upd_t;

  // Display contents read by the scan logic
  typedef struct packed {
    logic [3:0][3:0] digits;
    logic [1:0]      point;
    logic            volts;
  } avd_disp_t;

  // Seven-segment pattern, bit0 = a through bit6 = g
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/autorange_voltmeter_display_unit.sv
// Top level of the autoranging voltmeter with multiplexed four-digit display.
// Depends on avd_pkg, avd_accum, avd_scale, avd_scan and the macros header.
//
// Usage:
//   Input channel (in_valid/in_ready): in_action = 0 carries a converter
//   sample in in_sample; in_action = 1 is a display refresh tick.
//   Output channel (out_valid/out_ready): one item per tick with the segment
//   pattern, active-low digit enable and range LED. Samples give no item.
//   Every AVG_SAMPLES samples the average rescales the four stored digits.
// Timing:
//   Items pass an input register; a retired tick loads the result register,
//   which offers its result. One item per cycle is taken in steady state
//   while out_ready is high and no display update is in flight. The update
//   runs through a six-stage pipeline (accumulate, average, scale, divide
//   and clamp, quotients, digit store); a tick waiting behind a batch end
//   holds until the new digits are stored.
// Reset: synchronous, active low; digits read zero, millivolt range, point
//   on digit 0, scan at digit 0, accumulator empty.
// Stall: while out_ready is low the result holds and in_ready falls once
//   a tick waits in the input register; samples still drain.
`default_nettype none

`include "autorange_voltmeter_display_unit_macros.svh"

module autorange_voltmeter_display_unit
  import avd_pkg::*;
#(
  parameter int AVG_SAMPLES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [9:0] in_sample,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_segments,
  output logic [3:0]      out_digit_enable_n,
  output logic            out_range_led
);

  logic       in_valid_r;
  logic       in_action_r;
  logic [9:0] in_sample_r;
  logic       smp_go;
  logic       tick_go;
  logic       tick_room;
  logic       acc_busy;
  logic       scl_busy;
  avd_upd_t   upd;
  avd_disp_t  disp;

  // Retire held item: samples always, ticks once digits settle and output free
  assign smp_go   = in_valid_r && !in_action_r;
  assign tick_go  = in_valid_r && in_action_r && !acc_busy && !scl_busy && tick_room;
  assign in_ready = !in_valid_r || smp_go || tick_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_action_r <= in_action;
      in_sample_r <= in_sample;
    end
  end

  avd_accum #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .smp_go (smp_go),
    .sample (in_sample_r),
    .upd    (upd),
    .busy   (acc_busy)
  );

  avd_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .disp  (disp),
    .busy  (scl_busy)
  );

  avd_scan u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .tick_go            (tick_go),
    .disp               (disp),
    .tick_room          (tick_room),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_segments       (out_segments),
    .out_digit_enable_n (out_digit_enable_n),
    .out_range_led      (out_range_led)
  );

  // Checks
  `AVD_ASSERT_NOW(a_one_digit, out_valid, $countones(out_digit_enable_n) == 3,
                  "not one digit enabled")
  `AVD_ASSERT_NOW(a_volt_point, out_valid && out_range_led && !out_digit_enable_n[0],
                  out_segments[7], "volts point missing on digit 0")
  `AVD_ASSERT_NEXT(a_tick_result, tick_go, out_valid, "tick gave no result")

endmodule

`default_nettype wire

### hw/rtl/avd_accum.sv
// Sample accumulator and averaging stage of the voltmeter display.
// Depends on avd_pkg; feeds avd_scale with one average per batch.
`default_nettype none

module avd_accum
  import avd_pkg::*;
#(
  parameter int AVG_SAMPLES = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       smp_go,
  input  wire logic [9:0] sample,
  output avd_upd_t        upd,
  output logic            busy
);

  localparam int SUM_W = $clog2(1023 * AVG_SAMPLES + 1);
  localparam int CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
  localparam int LOG_N = $clog2(AVG_SAMPLES);
  localparam int SH_A  = SUM_W + LOG_N;
  localparam longint unsigned M_A_L =
    ((64'd1 << SH_A) + longint'(AVG_SAMPLES) - 64'd1) / longint'(AVG_SAMPLES);
  localparam logic [SUM_W:0] M_A = M_A_L[SUM_W:0];
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(AVG_SAMPLES - 1);

  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] tot_r;
  logic             tot_v_r;
  logic [9:0]       avg_r;
  logic             avg_v_r;
  logic [SUM_W-1:0] sum_add;
  logic [2*SUM_W:0] prod_a;

  assign sum_add = sum_r + SUM_W'(sample);

  // Accumulate samples; hand off the total at the end of a batch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      cnt_r   <= '0;
      tot_v_r <= 1'b0;
    end else begin
      tot_v_r <= smp_go && (cnt_r == LAST_CNT);
      if (smp_go) begin
        if (cnt_r == LAST_CNT) begin
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          sum_r <= sum_add;
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (smp_go && (cnt_r == LAST_CNT)) begin
      tot_r <= sum_add;
    end
  end

  // Truncated average by reciprocal multiply
  assign prod_a = {{(SUM_W + 1){1'b0}}, tot_r} * {{SUM_W{1'b0}}, M_A};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_v_r <= 1'b0;
    end else begin
      avg_v_r <= tot_v_r;
    end
  end

  always_ff @(posedge clk) begin
    avg_r <= prod_a[SH_A +: 10];
  end

  assign upd.valid = avg_v_r;
  assign upd.avg   = avg_r;
  assign busy      = tot_v_r | avg_v_r;

endmodule

`default_nettype wire

### hw/rtl/avd_scale.sv
// Range selection, scaling, clamping and digit split of the voltmeter display.
// Depends on avd_pkg; takes averages from avd_accum and holds the display digits.
`default_nettype none

module avd_scale
  import avd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  avd_upd_t  upd,
  output avd_disp_t disp,
  output logic      busy
);

  logic        c_v_r, d_v_r, e_v_r;
  logic        volts_c_r, volts_d_r, volts_e_r;
  logic [26:0] prod_c_r;
  logic [13:0] v_d_r;
  logic [13:0] v_e_r;
  logic [3:0]  q1000_r;
  logic [6:0]  q100_r;
  logic [9:0]  q10_r;
  avd_disp_t   disp_r;

  logic        volts_w;
  logic [16:0] k_w;
  logic [26:0] prod_w;
  logic [54:0] quo_w;
  logic [16:0] q_w;
  logic [16:0] lim_w;
  logic [13:0] v_w;
  logic [28:0] p1000_w, p100_w, p10_w;
  logic [6:0]  d1_w;
  logic [9:0]  d2_w;
  logic [13:0] d3_w;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      c_v_r <= upd.valid;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
    end
  end

  // Pick the range and scale with half-up rounding offset
  assign volts_w = (upd.avg >= VOLT_THRESH);
  assign k_w     = volts_w ? K_VOLT : K_MILLI;
  assign prod_w  = {17'd0, upd.avg} * {10'd0, k_w} + ROUND_ADD;

  always_ff @(posedge clk) begin
    prod_c_r  <= prod_w;
    volts_c_r <= volts_w;
  end

  // Divide by 2046 through reciprocal multiply, then clamp
  assign quo_w = {28'd0, prod_c_r} * {27'd0, M_2046};
  assign q_w   = quo_w[SH_2046 +: 17];
  assign lim_w = volts_c_r ? {3'd0, LIM_VOLT} : {3'd0, LIM_MILLI};
  assign v_w   = (q_w > lim_w) ? lim_w[13:0] : q_w[13:0];

  always_ff @(posedge clk) begin
    v_d_r     <= v_w;
    volts_d_r <= volts_c_r;
  end

  // Quotients by 1000, 100 and 10 in parallel
  assign p1000_w = {15'd0, v_d_r} * {14'd0, M_1000};
  assign p100_w  = {15'd0, v_d_r} * {14'd0, M_100};
  assign p10_w   = {15'd0, v_d_r} * {14'd0, M_10};

  always_ff @(posedge clk) begin
    q1000_r   <= p1000_w[SH_1000 +: 4];
    q100_r    <= p100_w[SH_100 +: 7];
    q10_r     <= p10_w[SH_10 +: 10];
    v_e_r     <= v_d_r;
    volts_e_r <= volts_d_r;
  end

  // Remainders by shift-add times ten
  assign d1_w = q100_r - ({3'd0, q1000_r} << 3) - ({3'd0, q1000_r} << 1);
  assign d2_w = q10_r - ({3'd0, q100_r} << 3) - ({3'd0, q100_r} << 1);
  assign d3_w = v_e_r - ({4'd0, q10_r} << 3) - ({4'd0, q10_r} << 1);

  // Store the new display contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_r <= '0;
    end else if (e_v_r) begin
      disp_r.digits[0] <= q1000_r;
      disp_r.digits[1] <= d1_w[3:0];
      disp_r.digits[2] <= d2_w[3:0];
      disp_r.digits[3] <= d3_w[3:0];
      disp_r.point     <= volts_e_r ? PT_VOLT : PT_MILLI;
      disp_r.volts     <= volts_e_r;
    end
  end

  assign disp = disp_r;
  assign busy = c_v_r | d_v_r | e_v_r;

endmodule

`default_nettype wire

### hw/rtl/avd_scan.sv
// Digit scan and result register of the voltmeter display.
// Depends on avd_pkg; reads the display contents held by avd_scale.
`default_nettype none

module avd_scan
  import avd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       tick_go,
  input  avd_disp_t       disp,
  output logic            tick_room,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_segments,
  output logic [3:0]      out_digit_enable_n,
  output logic            out_range_led
);

  logic [1:0] scan_r;
  logic       out_valid_r;
  logic [7:0] seg_r;
  logic [3:0] en_r;
  logic       led_r;
  logic [7:0] seg_w;

  assign tick_room = !out_valid_r || out_ready;

  // Pattern for the current digit, point added where it applies
  assign seg_w = seg_of(disp.digits[scan_r]) | ((disp.point == scan_r) ? DP_BIT : 8'h00);

  // Advance the scan and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (tick_go) begin
        scan_r      <= scan_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      seg_r <= seg_w;
      en_r  <= ~(4'b0001 << scan_r);
      led_r <= disp.volts;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_segments       = seg_r;
  assign out_digit_enable_n = en_r;
  assign out_range_led      = led_r;

endmodule

`default_nettype wire
